// ===== hdl/pss_pkg.sv =====
// Package: shared types, constants and codes for the particle swarm step block.
`default_nettype none
package pss_pkg;
    localparam int NUM_PARTICLES = 32;
    localparam int MAP_SIDE      = 64;
    localparam int PIDX_W        = 5;
    localparam int CIDX_W        = 6;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_PLACE = 2'd1;
    localparam logic [1:0] FUNC_MOVE  = 2'd2;

    localparam logic [2:0] REG_INERTIA = 3'd0;
    localparam logic [2:0] REG_COG     = 3'd1;
    localparam logic [2:0] REG_SOCIAL  = 3'd2;
    localparam logic [2:0] REG_WIDTH   = 3'd3;
    localparam logic [2:0] REG_HEIGHT  = 3'd4;

    localparam logic signed [17:0] POS_MAX = 18'sd131071;
    localparam logic signed [17:0] POS_MIN = -18'sd131072;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_A,
        ST_MUL_B,
        ST_VEL_X,
        ST_VEL_Y,
        ST_POS,
        ST_CELL,
        ST_UPDATE,
        ST_DONE
    } state_t;

    // Command from controller to datapath
    typedef struct packed {
        logic       load;     // capture item, read particle state
        logic       mul_a;    // first product set
        logic       mul_b;    // second product set
        logic       vel_x;    // add social terms for x and y
        logic       vel_y;    // combine and clamp x and y
        logic       pos;      // advance position
        logic       lookup;   // read map cell
        logic       update;   // write back state and bests
        logic       done;     // present result
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       valid;
    } dp_stat_t;
endpackage
`default_nettype wire

// ===== hdl/particle_swarm_step.sv =====
// Top level: particle swarm step, controller plus datapath.
// A move item goes read, multiply a and b, velocity x and y, position,
// cell, update, done; a place item read, cell, update, done; a map write or unused
// code read, done. busy stays high until the result strobe ends; a new item is
// taken only when idle. The receiver cannot stall: done is a one-cycle strobe.
// Reset is asynchronous, active low; it clears particles, bests and settings.
`default_nettype none
module particle_swarm_step (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output      logic               busy,
    output      logic               done,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic [1:0]         func,
    input  wire logic [4:0]         particle,
    input  wire logic [13:0]        place_x,
    input  wire logic [13:0]        place_y,
    input  wire logic [5:0]         cell_x,
    input  wire logic [5:0]         cell_y,
    input  wire logic signed [15:0] cell_value,
    input  wire logic [15:0]        rand_one,
    input  wire logic [15:0]        rand_two,
    output      logic signed [17:0] pos_x,
    output      logic signed [17:0] pos_y,
    output      logic signed [15:0] vel_x,
    output      logic signed [15:0] vel_y,
    output      logic               outside_map,
    output      logic               personal_improved,
    output      logic signed [17:0] best_x,
    output      logic signed [17:0] best_y,
    output      logic signed [15:0] best_value
);
    import pss_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequence each item through the datapath
    pss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // hold particle, map and best state; do the arithmetic
    pss_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .func              (func),
        .particle          (particle),
        .place_x           (place_x),
        .place_y           (place_y),
        .cell_x            (cell_x),
        .cell_y            (cell_y),
        .cell_value        (cell_value),
        .rand_one          (rand_one),
        .rand_two          (rand_two),
        .done              (done),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .vel_x             (vel_x),
        .vel_y             (vel_y),
        .outside_map       (outside_map),
        .personal_improved (personal_improved),
        .best_x            (best_x),
        .best_y            (best_y),
        .best_value        (best_value)
    );
endmodule
`default_nettype wire

// ===== hdl/pss_ctrl.sv =====
// Controller: sequences one item through the datapath.
`default_nettype none
module pss_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output      logic              busy,
    input  wire pss_pkg::dp_stat_t stat,
    output      pss_pkg::dp_cmd_t  cmd
);
    import pss_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start) state_next = ST_READ;
            ST_READ:
            begin
                if (stat.valid && stat.func == FUNC_MOVE)
                    state_next = ST_MUL_A;
                else if (stat.valid && stat.func == FUNC_PLACE)
                    state_next = ST_CELL;
                else
                    state_next = ST_DONE;
            end
            ST_MUL_A:  state_next = ST_MUL_B;
            ST_MUL_B:  state_next = ST_VEL_X;
            ST_VEL_X:  state_next = ST_VEL_Y;
            ST_VEL_Y:  state_next = ST_POS;
            ST_POS:    state_next = ST_CELL;
            ST_CELL:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        busy       = (state_reg != ST_IDLE);
        cmd.load   = (state_reg == ST_IDLE) && start;
        cmd.mul_a  = (state_reg == ST_MUL_A);
        cmd.mul_b  = (state_reg == ST_MUL_B);
        cmd.vel_x  = (state_reg == ST_VEL_X);
        cmd.vel_y  = (state_reg == ST_VEL_Y);
        cmd.pos    = (state_reg == ST_POS);
        cmd.lookup = (state_reg == ST_CELL);
        cmd.update = (state_reg == ST_UPDATE);
        cmd.done   = (state_reg == ST_DONE);
    end
endmodule
`default_nettype wire

// ===== hdl/pss_datapath.sv =====
// Datapath: particle store, map memory, velocity arithmetic and best tracking.
`default_nettype none
module pss_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pss_pkg::dp_cmd_t    cmd,
    output      pss_pkg::dp_stat_t   stat,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic [1:0]          func,
    input  wire logic [4:0]          particle,
    input  wire logic [13:0]         place_x,
    input  wire logic [13:0]         place_y,
    input  wire logic [5:0]          cell_x,
    input  wire logic [5:0]          cell_y,
    input  wire logic signed [15:0]  cell_value,
    input  wire logic [15:0]         rand_one,
    input  wire logic [15:0]         rand_two,
    output      logic                done,
    output      logic signed [17:0]  pos_x,
    output      logic signed [17:0]  pos_y,
    output      logic signed [15:0]  vel_x,
    output      logic signed [15:0]  vel_y,
    output      logic                outside_map,
    output      logic                personal_improved,
    output      logic signed [17:0]  best_x,
    output      logic signed [17:0]  best_y,
    output      logic signed [15:0]  best_value
);
    import pss_pkg::*;

    // configuration
    logic [15:0] w_reg, c1_reg, c2_reg;
    logic [6:0]  mw_reg, mh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg  <= 16'd11469;
            c1_reg <= 16'd24576;
            c2_reg <= 16'd24576;
            mw_reg <= 7'd64;
            mh_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INERTIA: w_reg  <= cfg_data;
                REG_COG:     c1_reg <= cfg_data;
                REG_SOCIAL:  c2_reg <= cfg_data;
                REG_WIDTH:   mw_reg <= cfg_data[6:0];
                REG_HEIGHT:  mh_reg <= cfg_data[6:0];
                default:     ;
            endcase
        end
    end

    // item capture
    logic [1:0]         func_reg;
    logic [4:0]         pidx_reg;
    logic               valid_reg;
    logic [13:0]        plx_reg, ply_reg;
    logic [15:0]        r1_reg, r2_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            pidx_reg <= particle;
            plx_reg  <= place_x;
            ply_reg  <= place_y;
            r1_reg   <= rand_one;
            r2_reg   <= rand_two;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.load)
            valid_reg <= ({27'd0, particle} < NUM_PARTICLES);
    end

    assign stat.func  = func_reg;
    assign stat.valid = valid_reg;

    // particle state; flip-flops with reset, read at the item's particle index
    logic signed [17:0] ppx_reg [NUM_PARTICLES];
    logic signed [17:0] ppy_reg [NUM_PARTICLES];
    logic signed [15:0] pvx_reg [NUM_PARTICLES];
    logic signed [15:0] pvy_reg [NUM_PARTICLES];
    logic signed [17:0] obx_reg [NUM_PARTICLES];
    logic signed [17:0] oby_reg [NUM_PARTICLES];
    logic signed [15:0] obv_reg [NUM_PARTICLES];
    logic signed [17:0] gbx_reg, gby_reg;
    logic signed [15:0] gbv_reg;

    // working registers
    logic signed [17:0] px_reg, py_reg, bx_reg, by_reg;
    logic signed [15:0] vx_reg, vy_reg, bv_reg;
    logic signed [17:0] nx_reg, ny_reg;
    logic signed [15:0] nvx_reg, nvy_reg;
    logic [31:0]        k1_reg, k2_reg;
    logic signed [47:0] tx_reg, ty_reg;
    logic signed [55:0] sx_reg, sy_reg;
    logic signed [15:0] lim_reg;
    logic               outside_reg, improved_reg;
    logic signed [15:0] cval_reg;
    logic               inside_reg;

    // map memory
    logic signed [15:0] map_mem [MAP_SIDE*MAP_SIDE];

    always_ff @(posedge clk)
    begin
        if (cmd.load && func == FUNC_WRITE)
            map_mem[{cell_y, cell_x}] <= cell_value;
    end

    // cell index, half away from zero
    function automatic logic signed [10:0] cell_of(input logic signed [17:0] p);
        logic [17:0] m;
        logic [18:0] r;
        begin
            m = p[17] ? 18'(-p) : 18'(p);
            r = {1'b0, m} + 19'd128;
            cell_of = p[17] ? -$signed({1'b0, r[17:8]}) : $signed({1'b0, r[17:8]});
        end
    endfunction

    // round the 46-fraction-bit sum to Q.8, ties up, then clamp to the limit
    function automatic logic signed [15:0] clamp(input logic signed [63:0] s,
                                                 input logic signed [15:0] lim);
        logic signed [63:0] t;
        logic signed [25:0] q;
        begin
            t = s + 64'sh20_0000_0000;
            q = 26'(t >>> 38);
            if (q > lim)
                clamp = lim;
            else if (q < -lim)
                clamp = -lim;
            else
                clamp = q[15:0];
        end
    endfunction

    function automatic logic signed [17:0] satp(input logic signed [18:0] p);
        begin
            if (p > 19'sd131071)
                satp = POS_MAX;
            else if (p < -19'sd131072)
                satp = POS_MIN;
            else
                satp = p[17:0];
        end
    endfunction

    logic signed [10:0] ix, iy;
    logic               in_map;
    logic [11:0]        cell_addr;

    assign ix = cell_of(nx_reg);
    assign iy = cell_of(ny_reg);
    assign in_map = !ix[10] && !iy[10] && (ix < $signed({4'd0, mw_reg}))
                  && (iy < $signed({4'd0, mh_reg})) && (ix < 11'sd64) && (iy < 11'sd64);
    assign cell_addr = {iy[5:0], ix[5:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            cval_reg <= map_mem[cell_addr];
        end
    end

    // limit: floor((w+h)*256/10) via reciprocal, exact for sums up to 254
    logic [7:0]  sum_wh;
    logic [30:0] lim_prod;
    assign sum_wh   = {1'b0, mw_reg} + {1'b0, mh_reg};
    assign lim_prod = {15'd0, sum_wh, 8'd0} * 31'd26215;

    // state read, products, velocity and position steps
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg  <= ppx_reg[particle];
            py_reg  <= ppy_reg[particle];
            vx_reg  <= pvx_reg[particle];
            vy_reg  <= pvy_reg[particle];
            bx_reg  <= obx_reg[particle];
            by_reg  <= oby_reg[particle];
            bv_reg  <= obv_reg[particle];
        end
        if (cmd.mul_a)
        begin
            k1_reg  <= c1_reg * r1_reg;
            k2_reg  <= c2_reg * r2_reg;
            lim_reg <= $signed({3'd0, lim_prod[30:18]});
        end
        if (cmd.mul_b)
        begin
            tx_reg <= $signed({1'b0, w_reg}) * vx_reg;
            ty_reg <= $signed({1'b0, w_reg}) * vy_reg;
            sx_reg <= $signed({1'b0, k1_reg}) * (bx_reg - px_reg);
            sy_reg <= $signed({1'b0, k1_reg}) * (by_reg - py_reg);
        end
        if (cmd.vel_x)
        begin
            sx_reg <= sx_reg + $signed({1'b0, k2_reg}) * (gbx_reg - px_reg);
            sy_reg <= sy_reg + $signed({1'b0, k2_reg}) * (gby_reg - py_reg);
        end
        if (cmd.vel_y)
        begin
            nvx_reg <= clamp(sx_reg + $signed({tx_reg, 16'd0}), lim_reg);
            nvy_reg <= clamp(sy_reg + $signed({ty_reg, 16'd0}), lim_reg);
        end
        if (cmd.pos)
        begin
            nx_reg <= satp({px_reg[17], px_reg} + {{3{nvx_reg[15]}}, nvx_reg});
            ny_reg <= satp({py_reg[17], py_reg} + {{3{nvy_reg[15]}}, nvy_reg});
        end
        else if (cmd.load)
        begin
            nx_reg <= $signed({4'd0, place_x});
            ny_reg <= $signed({4'd0, place_y});
        end
    end

    logic is_move;
    logic upd_pb, imp;
    assign is_move = (func_reg == FUNC_MOVE);
    assign imp     = cval_reg > bv_reg;
    assign upd_pb  = valid_reg && inside_reg && (!is_move || imp);

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
            inside_reg <= in_map;
    end

    integer i;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (i = 0; i < NUM_PARTICLES; i++)
            begin
                ppx_reg[i] <= '0;
                ppy_reg[i] <= '0;
                pvx_reg[i] <= '0;
                pvy_reg[i] <= '0;
                obx_reg[i] <= '0;
                oby_reg[i] <= '0;
                obv_reg[i] <= -16'sd1000;
            end
            gbx_reg <= -18'sd256;
            gby_reg <= -18'sd256;
            gbv_reg <= -16'sd9999;
        end
        else if (cmd.update && valid_reg)
        begin
            ppx_reg[pidx_reg] <= nx_reg;
            ppy_reg[pidx_reg] <= ny_reg;
            if (is_move)
            begin
                pvx_reg[pidx_reg] <= nvx_reg;
                pvy_reg[pidx_reg] <= nvy_reg;
            end
            if (upd_pb)
            begin
                obx_reg[pidx_reg] <= nx_reg;
                oby_reg[pidx_reg] <= ny_reg;
                obv_reg[pidx_reg] <= cval_reg;
                if (cval_reg > gbv_reg)
                begin
                    gbx_reg <= nx_reg;
                    gby_reg <= ny_reg;
                    gbv_reg <= cval_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outside_reg  <= 1'b0;
            improved_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            outside_reg  <= 1'b0;
            improved_reg <= 1'b0;
        end
        else if (cmd.update && valid_reg)
        begin
            outside_reg  <= !inside_reg;
            improved_reg <= inside_reg && imp;
        end
    end

    logic do_pm;
    assign do_pm = valid_reg;

    always_comb
    begin
        done              = cmd.done;
        pos_x             = do_pm ? ppx_reg[pidx_reg] : '0;
        pos_y             = do_pm ? ppy_reg[pidx_reg] : '0;
        vel_x             = do_pm ? pvx_reg[pidx_reg] : '0;
        vel_y             = do_pm ? pvy_reg[pidx_reg] : '0;
        outside_map       = outside_reg;
        personal_improved = improved_reg;
        best_x            = gbx_reg;
        best_y            = gby_reg;
        best_value        = gbv_reg;
    end
endmodule
`default_nettype wire
